@@ rtl/s2u128_pkg.sv @@
package s2u128_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } char_word_t;

  typedef struct packed {
    logic [63:0] value_low;
    logic [63:0] value_high;
  } value_word_t;

  typedef enum logic [2:0] {
    PH_FIRST      = 3'd0,
    PH_AFTER_SIGN = 3'd1,
    PH_AFTER_ZERO = 3'd2,
    PH_DIGITS     = 3'd3,
    PH_STOPPED    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } base_t;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7A;
  localparam logic [7:0] CharLowX  = 8'h78;

  localparam logic [5:0] LetterBase = 6'd10;
  localparam logic [4:0] RadixDec   = 5'd10;
  localparam logic [4:0] RadixOct   = 5'd8;
  localparam logic [4:0] RadixHex   = 5'd16;

endpackage

@@ rtl/string_to_u128_radix_parser_top.sv @@
// Channel   | Dir | Handshake              | Word
// char      | in  | char_valid/char_stall  | char_word_t  (char_code, end_of_string)
// value     | out | value_valid/value_stall| value_word_t (value_low, value_high)
//
// One character word is taken every cycle unless char_stall holds it; each word feeds the
// 128-bit shift-add (x8, x10 or x16 plus digit) into the accumulator.
// An end-of-string word loads the result register and clears the parse state
// in the same cycle; the result shows in the following cycle.
// Reset (rst, synchronous) empties the result register and restores the parse state.
// char_stall rises only for an end-of-string word while an earlier result is still stalled.
module string_to_u128_radix_parser_top
  import s2u128_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  char_word_t  char_word,
  output logic        value_valid,
  input  logic        value_stall,
  output value_word_t value_word
);

  logic [127:0] acc, acc_next;
  phase_t       phase, phase_next;
  base_t        base, base_next;
  logic         negative, negative_next;
  logic         out_valid;
  value_word_t  out_word;

  logic         char_take;
  logic         end_take;
  logic [5:0]   dval;
  logic         dletter;
  logic [4:0]   radix;
  logic         dok;
  logic [127:0] scaled;
  logic [127:0] result;

  assign char_stall  = out_valid && value_stall && char_word.end_of_string;
  assign char_take   = char_valid && !char_stall;
  assign end_take    = char_take && char_word.end_of_string;
  assign value_valid = out_valid;
  assign value_word  = out_word;

  // digit value of the incoming byte; dletter low means neither digit nor letter
  always_comb begin
    dval    = '0;
    dletter = 1'b0;
    if (char_word.char_code >= CharUpA && char_word.char_code <= CharUpZ) begin
      dval    = 6'(char_word.char_code - CharUpA) + LetterBase;
      dletter = 1'b1;
    end else if (char_word.char_code >= CharLowA && char_word.char_code <= CharLowZ) begin
      dval    = 6'(char_word.char_code - CharLowA) + LetterBase;
      dletter = 1'b1;
    end else if (char_word.char_code >= CharZero && char_word.char_code <= CharNine) begin
      dval    = 6'(char_word.char_code - CharZero);
      dletter = 1'b1;
    end
  end

  always_comb begin
    unique case (base)
      BASE_OCT: begin
        radix  = RadixOct;
        scaled = {acc[124:0], 3'b000};
      end
      BASE_HEX: begin
        radix  = RadixHex;
        scaled = {acc[123:0], 4'b0000};
      end
      default: begin
        radix  = RadixDec;
        scaled = {acc[124:0], 3'b000} + {acc[126:0], 1'b0};
      end
    endcase
  end

  assign dok = dletter && ({1'b0, radix} > dval);

  always_comb begin
    logic take_digit;
    take_digit    = 1'b0;
    acc_next      = acc;
    phase_next    = phase;
    base_next     = base;
    negative_next = negative;
    if (char_take) begin
      if (char_word.end_of_string) begin
        acc_next      = '0;
        phase_next    = PH_FIRST;
        base_next     = BASE_DEC;
        negative_next = 1'b0;
      end else begin
        unique case (phase)
          PH_FIRST: begin
            if (char_word.char_code == CharMinus) begin
              negative_next = 1'b1;
              phase_next    = PH_AFTER_SIGN;
            end else if (char_word.char_code == CharZero) begin
              base_next  = BASE_OCT;
              phase_next = PH_AFTER_ZERO;
            end else begin
              take_digit = 1'b1;
            end
          end
          PH_AFTER_SIGN: begin
            if (char_word.char_code == CharZero) begin
              base_next  = BASE_OCT;
              phase_next = PH_AFTER_ZERO;
            end else begin
              take_digit = 1'b1;
            end
          end
          PH_AFTER_ZERO: begin
            if (char_word.char_code == CharLowX) begin
              base_next  = BASE_HEX;
              phase_next = PH_DIGITS;
            end else begin
              take_digit = 1'b1;
            end
          end
          PH_DIGITS: take_digit = 1'b1;
          default:   phase_next = PH_STOPPED;
        endcase
        if (take_digit) begin
          if (dok) begin
            acc_next   = scaled + 128'(dval);
            phase_next = PH_DIGITS;
          end else begin
            // first invalid character: drop the rest of the string
            phase_next = PH_STOPPED;
          end
        end
      end
    end
  end

  assign result = negative ? (~acc + 128'd1) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      phase    <= PH_FIRST;
      base     <= BASE_DEC;
      negative <= 1'b0;
    end else begin
      acc      <= acc_next;
      phase    <= phase_next;
      base     <= base_next;
      negative <= negative_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (end_take) begin
      out_valid <= 1'b1;
    end else if (!value_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_take) begin
      out_word.value_low  <= result[63:0];
      out_word.value_high <= result[127:64];
    end
  end

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    end_take |=> value_valid)
    else $error("end of string word did not produce a result");

  a_end_clears_state: assert property (@(posedge clk) disable iff (rst)
    end_take |=> (phase == PH_FIRST && acc == '0 && !negative && base == BASE_DEC))
    else $error("parse state not cleared after end of string");

  a_stopped_holds: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_STOPPED && !end_take) |=> ($stable(acc) && phase == PH_STOPPED))
    else $error("accumulator moved after parsing stopped");

  a_hex_phase: assert property (@(posedge clk) disable iff (rst)
    (base == BASE_HEX) |-> (phase == PH_DIGITS || phase == PH_STOPPED))
    else $error("hex base outside digit phases");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (value_valid && value_stall) |=> (value_valid && $stable(value_word)))
    else $error("stalled result changed");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import s2u128_pkg::*;

  localparam int WatchdogLimit = 500;
  localparam int RandomChars   = 600;
  localparam int DrainCycles   = 4;
  localparam int PauseEvery    = 12;
  localparam logic [7:0] CharUpX = CharUpA + 8'd23;

  typedef struct {
    char_word_t   word;
    bit           lit;
    logic [127:0] val;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_stall;
  char_word_t  char_word = '0;
  logic        value_valid;
  logic        value_stall = 1'b0;
  value_word_t value_word;

  // parser state mirrored on the testbench side
  logic [127:0] parse_acc;
  phase_t       parse_phase;
  base_t        parse_base;
  logic         parse_neg;

  logic [127:0] value_q [$];
  stim_row_t    stim_table [$];

  int  errors       = 0;
  int  chars_sent   = 0;
  int  strings_sent = 0;
  int  values_seen  = 0;
  int  long_strings = 0;
  int  pauses       = 0;
  int  hold_left    = 0;
  int  idle_cycles  = 0;
  bit  quiet_tx     = 1'b0;
  bit  quiet_rx     = 1'b0;

  string_to_u128_radix_parser_top u_top (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_word  (char_word),
    .value_valid(value_valid),
    .value_stall(value_stall),
    .value_word (value_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] char_digit(input logic [7:0] c);
    if (c >= CharUpA && c <= CharUpZ) return c - CharUpA + LetterBase;
    if (c >= CharLowA && c <= CharLowZ) return c - CharLowA + LetterBase;
    if (c >= CharZero && c <= CharNine) return c - CharZero;
    return 8'hFF;
  endfunction

  function automatic logic [4:0] radix_of(input base_t b);
    case (b)
      BASE_OCT: return RadixOct;
      BASE_HEX: return RadixHex;
      default:  return RadixDec;
    endcase
  endfunction

  task automatic clear_parse();
    parse_acc   = '0;
    parse_phase = PH_FIRST;
    parse_base  = BASE_DEC;
    parse_neg   = 1'b0;
  endtask

  task automatic accumulate(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    d = char_digit(c);
    r = radix_of(parse_base);
    if (d >= {3'b000, r}) begin
      parse_phase = PH_STOPPED;
    end else begin
      parse_acc   = parse_acc * {123'd0, r} + {120'd0, d};
      parse_phase = PH_DIGITS;
    end
  endtask

  task automatic parse_word(input char_word_t w, output bit done, output logic [127:0] val);
    done = 1'b0;
    val  = '0;
    if (w.end_of_string) begin
      done = 1'b1;
      val  = parse_neg ? -parse_acc : parse_acc;
      clear_parse();
    end else begin
      case (parse_phase)
        PH_FIRST: begin
          if (w.char_code == CharMinus) begin
            parse_neg   = 1'b1;
            parse_phase = PH_AFTER_SIGN;
          end else if (w.char_code == CharZero) begin
            parse_base  = BASE_OCT;
            parse_phase = PH_AFTER_ZERO;
          end else begin
            accumulate(w.char_code);
          end
        end
        PH_AFTER_SIGN: begin
          if (w.char_code == CharZero) begin
            parse_base  = BASE_OCT;
            parse_phase = PH_AFTER_ZERO;
          end else begin
            accumulate(w.char_code);
          end
        end
        PH_AFTER_ZERO: begin
          if (w.char_code == CharLowX) begin
            parse_base  = BASE_HEX;
            parse_phase = PH_DIGITS;
          end else begin
            accumulate(w.char_code);
          end
        end
        PH_DIGITS: accumulate(w.char_code);
        default:   parse_phase = PH_STOPPED;
      endcase
    end
  endtask

  task automatic add_row(input logic [7:0] c, input logic eos, input bit lit,
                         input logic [127:0] val);
    stim_row_t row;
    row.word.char_code     = c;
    row.word.end_of_string = eos;
    row.lit = lit;
    row.val = val;
    stim_table.push_back(row);
  endtask

  task automatic send_char(input char_word_t w, input bit use_lit, input logic [127:0] lit);
    int           gap;
    bit           done;
    logic [127:0] val;
    gap = quiet_tx ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_word  <= w;
    do @(posedge clk); while (char_stall);
    chars_sent++;
    parse_word(w, done, val);
    if (done) value_q.push_back(use_lit ? lit : val);
  endtask

  task automatic send_random_string();
    logic [7:0] text [$];
    int         kind;
    int         len;
    int         d;
    logic [4:0] r;
    char_word_t w;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      // well-formed: sign, prefix, digits of the chosen radix
      if ($urandom_range(0, 1) == 1) text.push_back(CharMinus);
      case ($urandom_range(0, 2))
        0: r = RadixDec;
        1: begin
          r = RadixOct;
          text.push_back(CharZero);
        end
        default: begin
          r = RadixHex;
          text.push_back(CharZero);
          text.push_back(CharLowX);
        end
      endcase
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 45) : $urandom_range(0, 12);
      if (len >= 30) long_strings++;
      repeat (len) begin
        d = $urandom_range(0, r - 1);
        if (d < 10) text.push_back(CharZero + 8'(d));
        else text.push_back((($urandom_range(0, 1) == 1) ? CharUpA : CharLowA)
                            + 8'(d) - LetterBase);
      end
      // stop on a high byte, then trail some junk
      if ($urandom_range(0, 3) == 0) begin
        text.push_back(8'($urandom_range(128, 255)));
        repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(0, 255)));
      end
    end else if (kind <= 8) begin
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 7))
          0:       text.push_back(CharMinus);
          1:       text.push_back(CharZero);
          2:       text.push_back(CharLowX);
          3:       text.push_back(CharUpX);
          4:       text.push_back(CharZero + 8'($urandom_range(0, 9)));
          5:       text.push_back(CharUpA + 8'($urandom_range(0, 25)));
          6:       text.push_back(CharLowA + 8'($urandom_range(0, 25)));
          default: text.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      repeat ($urandom_range(0, 8)) text.push_back(8'($urandom_range(0, 255)));
    end
    foreach (text[i]) begin
      w.char_code     = text[i];
      w.end_of_string = 1'b0;
      send_char(w, 1'b0, '0);
    end
    w.char_code     = 8'($urandom_range(0, 255));
    w.end_of_string = 1'b1;
    send_char(w, 1'b0, '0);
  endtask

  always @(posedge clk) begin : value_check
    logic [127:0] want;
    if (!rst) begin
      if (value_valid && !value_stall) begin
        values_seen++;
        if (value_q.size() == 0) begin
          errors++;
          $display("%0t: value word with nothing expected: low %h high %h", $time,
                   value_word.value_low, value_word.value_high);
        end else begin
          want = value_q.pop_front();
          if (value_word.value_low !== want[63:0]) begin
            errors++;
            $display("%0t: value_low expected %h got %h", $time, want[63:0],
                     value_word.value_low);
          end
          if (value_word.value_high !== want[127:64]) begin
            errors++;
            $display("%0t: value_high expected %h got %h", $time, want[127:64],
                     value_word.value_high);
          end
        end
        hold_left = quiet_rx ? 0 : $urandom_range(0, 3);
        value_stall <= (hold_left != 0);
      end else if (value_valid && value_stall) begin
        // count the hold down only while a word is waiting
        hold_left--;
        value_stall <= (hold_left != 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (value_valid && !value_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no word moved for %0d cycles, %0d values outstanding", $time,
                 idle_cycles, value_q.size());
        $display("string_to_u128_radix_parser_top test failed");
        $finish;
      end
    end
  end

  initial begin
    clear_parse();
    // empty string
    add_row(8'h00, 1'b1, 1'b1, '0);
    // sign only
    add_row(CharMinus, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b1, '0);
    // uppercase X is no prefix and stops octal
    add_row(CharZero, 1'b0, 1'b0, '0);
    add_row(CharUpX, 1'b0, 1'b0, '0);
    add_row(CharZero + 8'd1, 1'b0, 1'b0, '0);
    add_row(8'h5A, 1'b1, 1'b1, '0);
    // high byte stops before any digit
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(CharZero + 8'd7, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b1, 1'b1, '0);
    // negative hex, mixed case, stopped by a letter past the radix
    add_row(CharMinus, 1'b0, 1'b0, '0);
    add_row(CharZero, 1'b0, 1'b0, '0);
    add_row(CharLowX, 1'b0, 1'b0, '0);
    add_row(CharUpA + 8'd5, 1'b0, 1'b0, '0);
    add_row(CharLowA, 1'b0, 1'b0, '0);
    add_row(CharLowZ, 1'b0, 1'b0, '0);
    add_row(8'hAA, 1'b1, 1'b0, '0);
    // octal stopped by an eight
    add_row(CharZero, 1'b0, 1'b0, '0);
    add_row(CharZero + 8'd7, 1'b0, 1'b0, '0);
    add_row(CharZero + 8'd8, 1'b0, 1'b0, '0);
    add_row(8'h55, 1'b1, 1'b0, '0);
    // decimal stopped by a minus after a digit, then an uppercase Z
    add_row(CharNine, 1'b0, 1'b0, '0);
    add_row(CharMinus, 1'b0, 1'b0, '0);
    add_row(CharUpZ, 1'b0, 1'b0, '0);
    add_row(8'h7F, 1'b1, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) send_char(stim_table[i].word, stim_table[i].lit, stim_table[i].val);

    while (chars_sent < stim_table.size() + RandomChars) begin
      quiet_tx = ($urandom_range(0, 4) == 0);
      quiet_rx = ($urandom_range(0, 4) == 0);
      send_random_string();
      strings_sent++;
      // hold the sender until every value is out
      if (strings_sent % PauseEvery == 0) begin
        char_valid <= 1'b0;
        @(posedge clk);
        while (value_q.size() != 0) @(posedge clk);
        pauses++;
      end
    end

    char_valid <= 1'b0;
    @(posedge clk);
    while (value_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d character words in %0d random strings (%0d long), %0d drain pauses.",
             chars_sent, strings_sent, long_strings, pauses);
    $display("Checked %0d value words, %0d mismatches.", values_seen, errors);
    if (errors == 0) begin
      $display("string_to_u128_radix_parser_top test passed");
    end else begin
      $display("string_to_u128_radix_parser_top test failed");
    end
    $finish;
  end

endmodule
